// ----- rtl/core/tlik_pkg.sv -----
// shared types, constants and helper functions of the leg inverse kinematics pipeline
package tlik_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int IN_W          = 24;
    localparam int OUT_W         = 20;
    localparam int LINK_W        = 20;
    localparam int LEN_W         = LINK_W + 1;
    localparam logic [LINK_W-1:0] LINK_RESET = 20'd13107;

    localparam int ARG_BITS     = 30;
    localparam int ANG_FRAC     = 60;
    localparam int ANG_W        = 64;
    localparam int CXW          = 62;
    localparam int CORDIC_STEPS = 60;
    localparam int NORM_STEPS   = 6;
    localparam int NORM_TOP     = 56;
    localparam int LANES        = 3;

    localparam logic signed [ANG_W-1:0] PI_Q60         = 64'sh3243F6A8885A308D;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q60    = 64'sh1921FB54442D1846;
    localparam logic signed [ANG_W-1:0] QUARTER_PI_Q60 = 64'sh0C90FDAA22168C23;

    typedef enum logic {
        REG_UPPER = 1'b0,
        REG_LOWER = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        BASE_ZERO        = 3'd0,
        BASE_PI          = 3'd1,
        BASE_NEG_PI      = 3'd2,
        BASE_HALF_PI     = 3'd3,
        BASE_NEG_HALF_PI = 3'd4
    } base_t;

    typedef struct packed {
        logic signed [CXW-1:0]   x;
        logic signed [CXW-1:0]   y;
        logic signed [ANG_W-1:0] ang;
        base_t                   base;
        logic                    direct;
    } lane_t;

    // atan(2^-i) in q60 from its power series
    function automatic logic signed [ANG_W-1:0] atan_step(input int i);
        logic signed [ANG_W-1:0] sum;
        logic [ANG_W-1:0]        term;
        int                      sh;
        sum = '0;
        if (i == 0) begin
            return QUARTER_PI_Q60;
        end
        for (int k = 0; k < 32; k++) begin
            sh = ANG_FRAC - i * (2 * k + 1);
            if (sh >= 0) begin
                term = (64'd1 << sh) / 64'(2 * k + 1);
                if (k[0]) begin
                    sum = sum - $signed(term);
                end
                else begin
                    sum = sum + $signed(term);
                end
            end
        end
        return sum;
    endfunction

    function automatic logic signed [ANG_W-1:0] base_value(input base_t b);
        logic signed [ANG_W-1:0] v;
        unique case (b)
            BASE_ZERO:        v = '0;
            BASE_PI:          v = PI_Q60;
            BASE_NEG_PI:      v = -PI_Q60;
            BASE_HALF_PI:     v = HALF_PI_Q60;
            BASE_NEG_HALF_PI: v = -HALF_PI_Q60;
            default:          v = '0;
        endcase
        return v;
    endfunction

    // axis cases and left half plane folding ahead of the cordic
    function automatic lane_t atan2_prep(input logic signed [CXW-1:0] y,
                                         input logic signed [CXW-1:0] x);
        lane_t l;
        l.x      = x;
        l.y      = y;
        l.ang    = '0;
        l.base   = BASE_ZERO;
        l.direct = 1'b0;
        priority if (y == '0) begin
            l.direct = 1'b1;
            l.base   = (x < 0) ? BASE_PI : BASE_ZERO;
        end
        else if (x == '0) begin
            l.direct = 1'b1;
            l.base   = (y > 0) ? BASE_HALF_PI : BASE_NEG_HALF_PI;
        end
        else if (x < 0) begin
            l.base = (y > 0) ? BASE_PI : BASE_NEG_PI;
            l.x    = -x;
            l.y    = -y;
        end
        return l;
    endfunction

endpackage

// ----- rtl/core/tlik_sqrt_cell.sv -----
// one digit cell of the pipelined integer square root
module tlik_sqrt_cell #(
    parameter int NW    = 48,
    parameter int LANES = 1,
    parameter int PW    = 1,
    parameter int STEP  = 0
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     vld_in,
    input  logic [LANES-1:0][NW-1:0] n_in,
    input  logic [LANES-1:0][NW-1:0] res_in,
    input  logic [PW-1:0]            side_in,
    output logic                     vld_out,
    output logic [LANES-1:0][NW-1:0] n_out,
    output logic [LANES-1:0][NW-1:0] res_out,
    output logic [PW-1:0]            side_out
);
    localparam logic [NW:0] BIT = {{NW{1'b0}}, 1'b1} << (NW - 2 - 2 * STEP);

    logic                     vld_reg;
    logic [LANES-1:0][NW-1:0] n_reg, n_next;
    logic [LANES-1:0][NW-1:0] res_reg, res_next;
    logic [PW-1:0]            side_reg;

    always_comb
    begin
        logic [NW:0] trial;
        for (int j = 0; j < LANES; j++) begin
            trial = {1'b0, res_in[j]} + BIT;
            if ({1'b0, n_in[j]} >= trial) begin
                n_next[j]   = n_in[j] - trial[NW-1:0];
                res_next[j] = (res_in[j] >> 1) + BIT[NW-1:0];
            end
            else begin
                n_next[j]   = n_in[j];
                res_next[j] = res_in[j] >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= 1'b0;
        end
        else begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        res_reg  <= res_next;
        side_reg <= side_in;
    end

    assign vld_out  = vld_reg;
    assign n_out    = n_reg;
    assign res_out  = res_reg;
    assign side_out = side_reg;

endmodule

// ----- rtl/core/tlik_div_cell.sv -----
// one quotient bit cell of the pipelined restoring divider
module tlik_div_cell #(
    parameter int RW    = 44,
    parameter int QW    = 30,
    parameter int LANES = 2,
    parameter int PW    = 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     vld_in,
    input  logic [LANES-1:0][RW-1:0] r_in,
    input  logic [LANES-1:0][RW-1:0] den_in,
    input  logic [LANES-1:0][QW-1:0] q_in,
    input  logic [PW-1:0]            side_in,
    output logic                     vld_out,
    output logic [LANES-1:0][RW-1:0] r_out,
    output logic [LANES-1:0][RW-1:0] den_out,
    output logic [LANES-1:0][QW-1:0] q_out,
    output logic [PW-1:0]            side_out
);
    logic                     vld_reg;
    logic [LANES-1:0][RW-1:0] r_reg, r_next;
    logic [LANES-1:0][RW-1:0] den_reg;
    logic [LANES-1:0][QW-1:0] q_reg, q_next;
    logic [PW-1:0]            side_reg;

    always_comb
    begin
        logic [RW:0] r2;
        logic [RW:0] diff;
        for (int j = 0; j < LANES; j++) begin
            r2   = {r_in[j], 1'b0};
            diff = r2 - {1'b0, den_in[j]};
            if (r2 >= {1'b0, den_in[j]}) begin
                r_next[j] = diff[RW-1:0];
                q_next[j] = {q_in[j][QW-2:0], 1'b1};
            end
            else begin
                r_next[j] = r2[RW-1:0];
                q_next[j] = {q_in[j][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= 1'b0;
        end
        else begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg    <= r_next;
        den_reg  <= den_in;
        q_reg    <= q_next;
        side_reg <= side_in;
    end

    assign vld_out  = vld_reg;
    assign r_out    = r_reg;
    assign den_out  = den_reg;
    assign q_out    = q_reg;
    assign side_out = side_reg;

endmodule

// ----- rtl/core/tlik_cordic_cell.sv -----
// one vectoring mode cordic iteration for all angle lanes
module tlik_cordic_cell #(
    parameter int STEP  = 0,
    parameter int LANES = 3
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            vld_in,
    input  tlik_pkg::lane_t [LANES-1:0]     lane_in,
    output logic                            vld_out,
    output tlik_pkg::lane_t [LANES-1:0]     lane_out
);
    import tlik_pkg::*;

    localparam logic signed [ANG_W-1:0] ATAN = atan_step(STEP);

    logic                  vld_reg;
    lane_t [LANES-1:0]     lane_reg, lane_next;

    always_comb
    begin
        logic signed [CXW-1:0] dx;
        logic signed [CXW-1:0] dy;
        lane_next = lane_in;
        for (int j = 0; j < LANES; j++) begin
            dx = $signed(lane_in[j].y) >>> STEP;
            dy = $signed(lane_in[j].x) >>> STEP;
            if ($signed(lane_in[j].y) >= 0) begin
                lane_next[j].x   = lane_in[j].x + dx;
                lane_next[j].y   = lane_in[j].y - dy;
                lane_next[j].ang = lane_in[j].ang + ATAN;
            end
            else begin
                lane_next[j].x   = lane_in[j].x - dx;
                lane_next[j].y   = lane_in[j].y + dy;
                lane_next[j].ang = lane_in[j].ang - ATAN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= 1'b0;
        end
        else begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
    end

    assign vld_out  = vld_reg;
    assign lane_out = lane_reg;

endmodule

// ----- rtl/core/two_link_leg_inverse_kinematics.sv -----
// top level: two link leg inverse kinematics pipeline
// throughput: one target per cycle, busy is always low
// depth set by two square root chains, the 30 cell divider and the 60 cell cordic
// done is a one cycle strobe, the receiver cannot stall it
// reset clears all valid bits and sets both link lengths to 0.2 m
module two_link_leg_inverse_kinematics #(
    parameter int FRAC_BITS = tlik_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic                                 wr_index,
    input  logic [tlik_pkg::LINK_W-1:0]          wr_data,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [tlik_pkg::IN_W-1:0]     target_x,
    input  logic signed [tlik_pkg::IN_W-1:0]     target_y,
    input  logic signed [tlik_pkg::IN_W-1:0]     target_z,
    output logic                                 done,
    output logic signed [tlik_pkg::OUT_W-1:0]    hip_angle,
    output logic signed [tlik_pkg::OUT_W-1:0]    knee_angle
);
    import tlik_pkg::*;

    localparam int SQL_NW  = 2 * IN_W;
    localparam int SQL_N   = SQL_NW / 2;
    localparam int SQA_NW  = 2 * ARG_BITS + 2;
    localparam int SQA_N   = SQA_NW / 2;
    localparam int XZ_W    = 2 * IN_W;
    localparam int DIV_RW  = 44;
    localparam int NUM_W   = DIV_RW + 1;
    localparam int Q_W     = ARG_BITS + 2;
    localparam int QSQ_W   = 2 * ARG_BITS + 1;
    localparam int DIV_PW  = XZ_W + 4;
    localparam int SQA_PW  = XZ_W + 2 * Q_W;
    localparam int RND_SH  = ANG_FRAC - FRAC_BITS;
    localparam int LMIN_RAW = ((1 << FRAC_BITS) + 500) / 1000;
    localparam int LMIN    = (LMIN_RAW < 1) ? 1 : LMIN_RAW;
    localparam logic [LEN_W-1:0] LMIN_V = LEN_W'(LMIN);
    localparam int LAT = 2 + SQL_N + 3 + ARG_BITS + 3 + SQA_N + 1 + NORM_STEPS
                         + CORDIC_STEPS + 4;
    localparam logic signed [Q_W-1:0] Q_ONE = Q_W'(1) <<< ARG_BITS;
    localparam logic signed [ANG_W+1:0] OMAX = ((ANG_W+2)'(1) <<< (OUT_W - 1)) - 1;
    localparam logic signed [ANG_W+1:0] OMIN = -((ANG_W+2)'(1) <<< (OUT_W - 1));

    function automatic logic signed [OUT_W-1:0] to_out(input logic signed [ANG_W-1:0] v);
        logic signed [ANG_W+1:0] w;
        logic signed [ANG_W+1:0] r;
        w = (ANG_W+2)'(v) + ((ANG_W+2)'(1) <<< (RND_SH - 1));
        r = w >>> RND_SH;
        if (r > OMAX) begin
            r = OMAX;
        end
        if (r < OMIN) begin
            r = OMIN;
        end
        return r[OUT_W-1:0];
    endfunction

    function automatic logic norm_ok(input lane_t l);
        logic [CXW-1:0] ax;
        logic [CXW-1:0] ay;
        ax = (l.x < 0) ? -l.x : l.x;
        ay = (l.y < 0) ? -l.y : l.y;
        return l.direct || ((ax | ay) >= (CXW'(1) << NORM_TOP));
    endfunction

    // link length registers
    logic [LINK_W-1:0] l1_reg, l2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            l1_reg <= LINK_RESET;
            l2_reg <= LINK_RESET;
        end
        else if (wr_en) begin
            unique case (reg_idx_t'(wr_index))
                REG_UPPER: l1_reg <= wr_data;
                REG_LOWER: l2_reg <= wr_data;
            endcase
        end
    end

    assign busy = 1'b0;

    // squares and sum
    logic                vld_a_reg, vld_b_reg;
    logic [SQL_NW-1:0]   xx_a_reg, yy_a_reg, zz_a_reg, sum_b_reg;
    logic [XZ_W-1:0]     xz_a_reg, xz_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end
        else begin
            vld_a_reg <= start && !busy;
            vld_b_reg <= vld_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        xx_a_reg  <= SQL_NW'(target_x * target_x);
        yy_a_reg  <= SQL_NW'(target_y * target_y);
        zz_a_reg  <= SQL_NW'(target_z * target_z);
        xz_a_reg  <= {target_x, target_z};
        sum_b_reg <= xx_a_reg + yy_a_reg + zz_a_reg;
        xz_b_reg  <= xz_a_reg;
    end

    // distance square root chain
    logic                    sql_vld  [0:SQL_N];
    logic [0:0][SQL_NW-1:0]  sql_n    [0:SQL_N];
    logic [0:0][SQL_NW-1:0]  sql_res  [0:SQL_N];
    logic [XZ_W-1:0]         sql_side [0:SQL_N];

    assign sql_vld[0]  = vld_b_reg;
    assign sql_n[0]    = sum_b_reg;
    assign sql_res[0]  = '0;
    assign sql_side[0] = xz_b_reg;

    for (genvar g = 0; g < SQL_N; g++) begin : g_sql
        tlik_sqrt_cell #(
            .NW    (SQL_NW),
            .LANES (1),
            .PW    (XZ_W),
            .STEP  (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .vld_in   (sql_vld[g]),
            .n_in     (sql_n[g]),
            .res_in   (sql_res[g]),
            .side_in  (sql_side[g]),
            .vld_out  (sql_vld[g+1]),
            .n_out    (sql_n[g+1]),
            .res_out  (sql_res[g+1]),
            .side_out (sql_side[g+1])
        );
    end

    // clamp, products, law of cosines terms
    logic                vld_c_reg, vld_d_reg, vld_e_reg;
    logic [LEN_W-1:0]    len_c_reg, len_c_next;
    logic [XZ_W-1:0]     xz_c_reg, xz_d_reg, xz_e_reg;
    logic [2*LINK_W-1:0] p11_d_reg, p22_d_reg, p12_d_reg;
    logic [2*LEN_W-1:0]  pll_d_reg;
    logic [LINK_W+LEN_W-1:0] p1l_d_reg;
    logic [1:0][DIV_RW-1:0] mag_e_reg, mag_e_next, den_e_reg, den_e_next;
    logic [1:0]          sat_e_reg, sat_e_next, neg_e_reg, neg_e_next;

    always_comb
    begin
        logic [LEN_W-1:0]  lsum;
        logic [IN_W-1:0]   root;
        logic [LEN_W-1:0]  len_pre;
        lsum    = {1'b0, l1_reg} + {1'b0, l2_reg};
        root    = sql_res[SQL_N][0][IN_W-1:0];
        len_pre = (root > IN_W'(lsum)) ? lsum : root[LEN_W-1:0];
        len_c_next = (len_pre < LMIN_V) ? LMIN_V : len_pre;
    end

    always_comb
    begin
        logic signed [NUM_W-1:0] num [2];
        logic [NUM_W-1:0]        mag;
        num[0] = $signed(NUM_W'(p11_d_reg)) + $signed(NUM_W'(pll_d_reg))
                 - $signed(NUM_W'(p22_d_reg));
        num[1] = $signed(NUM_W'(p11_d_reg)) + $signed(NUM_W'(p22_d_reg))
                 - $signed(NUM_W'(pll_d_reg));
        den_e_next[0] = DIV_RW'({p1l_d_reg, 1'b0});
        den_e_next[1] = DIV_RW'({p12_d_reg, 1'b0});
        for (int j = 0; j < 2; j++) begin
            mag           = (num[j] < 0) ? NUM_W'(-num[j]) : NUM_W'(num[j]);
            mag_e_next[j] = mag[DIV_RW-1:0];
            neg_e_next[j] = num[j] < 0;
            sat_e_next[j] = mag[DIV_RW-1:0] >= den_e_next[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_c_reg <= 1'b0;
            vld_d_reg <= 1'b0;
            vld_e_reg <= 1'b0;
        end
        else begin
            vld_c_reg <= sql_vld[SQL_N];
            vld_d_reg <= vld_c_reg;
            vld_e_reg <= vld_d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        len_c_reg <= len_c_next;
        xz_c_reg  <= sql_side[SQL_N];
        p11_d_reg <= l1_reg * l1_reg;
        p22_d_reg <= l2_reg * l2_reg;
        p12_d_reg <= l1_reg * l2_reg;
        pll_d_reg <= len_c_reg * len_c_reg;
        p1l_d_reg <= l1_reg * len_c_reg;
        xz_d_reg  <= xz_c_reg;
        mag_e_reg <= mag_e_next;
        den_e_reg <= den_e_next;
        sat_e_reg <= sat_e_next;
        neg_e_reg <= neg_e_next;
        xz_e_reg  <= xz_d_reg;
    end

    // divider chain for both arccosine arguments
    logic                        dv_vld  [0:ARG_BITS];
    logic [1:0][DIV_RW-1:0]      dv_r    [0:ARG_BITS];
    logic [1:0][DIV_RW-1:0]      dv_den  [0:ARG_BITS];
    logic [1:0][ARG_BITS-1:0]    dv_q    [0:ARG_BITS];
    logic [DIV_PW-1:0]           dv_side [0:ARG_BITS];

    assign dv_vld[0]  = vld_e_reg;
    assign dv_r[0]    = mag_e_reg;
    assign dv_den[0]  = den_e_reg;
    assign dv_q[0]    = '0;
    assign dv_side[0] = {xz_e_reg, sat_e_reg, neg_e_reg};

    for (genvar g = 0; g < ARG_BITS; g++) begin : g_div
        tlik_div_cell #(
            .RW    (DIV_RW),
            .QW    (ARG_BITS),
            .LANES (2),
            .PW    (DIV_PW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .vld_in   (dv_vld[g]),
            .r_in     (dv_r[g]),
            .den_in   (dv_den[g]),
            .q_in     (dv_q[g]),
            .side_in  (dv_side[g]),
            .vld_out  (dv_vld[g+1]),
            .r_out    (dv_r[g+1]),
            .den_out  (dv_den[g+1]),
            .q_out    (dv_q[g+1]),
            .side_out (dv_side[g+1])
        );
    end

    // signed argument, its square and 1 - a^2
    logic                         vld_f_reg, vld_g_reg, vld_h_reg;
    logic signed [1:0][Q_W-1:0]   q_f_reg, q_f_next, q_g_reg, q_h_reg;
    logic [1:0][QSQ_W-1:0]        qsq_g_reg, qsq_g_next;
    logic [1:0][SQA_NW-1:0]       arg_h_reg, arg_h_next;
    logic [XZ_W-1:0]              xz_f_reg, xz_g_reg, xz_h_reg;

    always_comb
    begin
        logic [1:0]              sat;
        logic [1:0]              neg;
        logic signed [Q_W-1:0]   mag;
        logic signed [2*Q_W-1:0] prod;
        sat = dv_side[ARG_BITS][3:2];
        neg = dv_side[ARG_BITS][1:0];
        for (int j = 0; j < 2; j++) begin
            mag         = sat[j] ? Q_ONE : $signed(Q_W'(dv_q[ARG_BITS][j]));
            q_f_next[j] = neg[j] ? -mag : mag;
            prod          = $signed(q_f_reg[j]) * $signed(q_f_reg[j]);
            qsq_g_next[j] = prod[QSQ_W-1:0];
            arg_h_next[j] = (SQA_NW'(1) << (2 * ARG_BITS)) - SQA_NW'(qsq_g_reg[j]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_f_reg <= 1'b0;
            vld_g_reg <= 1'b0;
            vld_h_reg <= 1'b0;
        end
        else begin
            vld_f_reg <= dv_vld[ARG_BITS];
            vld_g_reg <= vld_f_reg;
            vld_h_reg <= vld_g_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        q_f_reg   <= q_f_next;
        xz_f_reg  <= dv_side[ARG_BITS][DIV_PW-1:4];
        q_g_reg   <= q_f_reg;
        qsq_g_reg <= qsq_g_next;
        xz_g_reg  <= xz_f_reg;
        q_h_reg   <= q_g_reg;
        arg_h_reg <= arg_h_next;
        xz_h_reg  <= xz_g_reg;
    end

    // square root chain for sqrt(1 - a^2)
    logic                        sqa_vld  [0:SQA_N];
    logic [1:0][SQA_NW-1:0]      sqa_n    [0:SQA_N];
    logic [1:0][SQA_NW-1:0]      sqa_res  [0:SQA_N];
    logic [SQA_PW-1:0]           sqa_side [0:SQA_N];

    assign sqa_vld[0]  = vld_h_reg;
    assign sqa_n[0]    = arg_h_reg;
    assign sqa_res[0]  = '0;
    assign sqa_side[0] = {xz_h_reg, q_h_reg};

    for (genvar g = 0; g < SQA_N; g++) begin : g_sqa
        tlik_sqrt_cell #(
            .NW    (SQA_NW),
            .LANES (2),
            .PW    (SQA_PW),
            .STEP  (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .vld_in   (sqa_vld[g]),
            .n_in     (sqa_n[g]),
            .res_in   (sqa_res[g]),
            .side_in  (sqa_side[g]),
            .vld_out  (sqa_vld[g+1]),
            .n_out    (sqa_n[g+1]),
            .res_out  (sqa_res[g+1]),
            .side_out (sqa_side[g+1])
        );
    end

    // lane setup and normalizing shifts
    logic                  norm_vld_reg  [0:NORM_STEPS];
    lane_t [LANES-1:0]     norm_lane_reg [0:NORM_STEPS];
    lane_t [LANES-1:0]     prep_next;

    always_comb
    begin
        logic signed [IN_W-1:0]     tx;
        logic signed [IN_W-1:0]     tz;
        logic [1:0][Q_W-1:0]        qv;
        logic signed [Q_W-1:0]      qs;
        tx = $signed(sqa_side[SQA_N][SQA_PW-1 -: IN_W]);
        tz = $signed(sqa_side[SQA_N][SQA_PW-IN_W-1 -: IN_W]);
        qv = sqa_side[SQA_N][2*Q_W-1:0];
        prep_next[0] = atan2_prep(CXW'(tx), CXW'(tz));
        for (int j = 0; j < 2; j++) begin
            qs = $signed(qv[j]);
            prep_next[j+1] = atan2_prep($signed(CXW'(sqa_res[SQA_N][j][ARG_BITS:0])),
                                        CXW'(qs));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            norm_vld_reg[0] <= 1'b0;
        end
        else begin
            norm_vld_reg[0] <= sqa_vld[SQA_N];
        end
    end

    always_ff @(posedge clk)
    begin
        norm_lane_reg[0] <= prep_next;
    end

    for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
        localparam int SH = 32 >> k;
        lane_t [LANES-1:0] norm_lane_next;

        always_comb
        begin
            logic [CXW-1:0] ax;
            logic [CXW-1:0] ay;
            norm_lane_next = norm_lane_reg[k];
            for (int j = 0; j < LANES; j++) begin
                ax = (norm_lane_reg[k][j].x < 0) ? -norm_lane_reg[k][j].x
                                                 : norm_lane_reg[k][j].x;
                ay = (norm_lane_reg[k][j].y < 0) ? -norm_lane_reg[k][j].y
                                                 : norm_lane_reg[k][j].y;
                if ((ax | ay) < (CXW'(1) << (NORM_TOP + 1 - SH))) begin
                    norm_lane_next[j].x = norm_lane_reg[k][j].x <<< SH;
                    norm_lane_next[j].y = norm_lane_reg[k][j].y <<< SH;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                norm_vld_reg[k+1] <= 1'b0;
            end
            else begin
                norm_vld_reg[k+1] <= norm_vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            norm_lane_reg[k+1] <= norm_lane_next;
        end
    end

    // cordic chain
    logic               cor_vld  [0:CORDIC_STEPS];
    lane_t [LANES-1:0]  cor_lane [0:CORDIC_STEPS];

    assign cor_vld[0]  = norm_vld_reg[NORM_STEPS];
    assign cor_lane[0] = norm_lane_reg[NORM_STEPS];

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cor
        tlik_cordic_cell #(
            .STEP  (g),
            .LANES (LANES)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .vld_in   (cor_vld[g]),
            .lane_in  (cor_lane[g]),
            .vld_out  (cor_vld[g+1]),
            .lane_out (cor_lane[g+1])
        );
    end

    // angle sums and output rounding
    logic                     vld_s1_reg, vld_s2_reg, vld_s3_reg, done_reg;
    logic signed [ANG_W-1:0]  t_s1_reg [LANES];
    logic signed [ANG_W-1:0]  t_s1_next [LANES];
    logic signed [ANG_W-1:0]  t0_s2_reg, t1_s2_reg, knee_s2_reg;
    logic signed [ANG_W-1:0]  hip_s3_reg, knee_s3_reg;
    logic signed [OUT_W-1:0]  hip_reg, knee_reg;

    always_comb
    begin
        for (int j = 0; j < LANES; j++) begin
            t_s1_next[j] = base_value(cor_lane[CORDIC_STEPS][j].base)
                           + (cor_lane[CORDIC_STEPS][j].direct ? '0
                              : cor_lane[CORDIC_STEPS][j].ang);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_s1_reg <= 1'b0;
            vld_s2_reg <= 1'b0;
            vld_s3_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else begin
            vld_s1_reg <= cor_vld[CORDIC_STEPS];
            vld_s2_reg <= vld_s1_reg;
            vld_s3_reg <= vld_s2_reg;
            done_reg   <= vld_s3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t_s1_reg    <= t_s1_next;
        t0_s2_reg   <= (t_s1_reg[0] > 0) ? t_s1_reg[0] - PI_Q60 : t_s1_reg[0] + PI_Q60;
        t1_s2_reg   <= t_s1_reg[1];
        knee_s2_reg <= t_s1_reg[2] - PI_Q60;
        hip_s3_reg  <= t0_s2_reg + t1_s2_reg;
        knee_s3_reg <= knee_s2_reg;
        hip_reg     <= to_out(hip_s3_reg);
        knee_reg    <= to_out(knee_s3_reg);
    end

    assign done       = done_reg;
    assign hip_angle  = hip_reg;
    assign knee_angle = knee_reg;

`ifndef ASSERT_OFF
    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted target did not produce a result beat on time");

    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result beat without an accepted target");

    a_arg_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_f_reg |-> ($signed(q_f_reg[0]) <= Q_ONE && $signed(q_f_reg[0]) >= -Q_ONE
                       && $signed(q_f_reg[1]) <= Q_ONE && $signed(q_f_reg[1]) >= -Q_ONE))
        else $error("arccosine argument outside unit range");

    a_norm_done: assert property (@(posedge clk) disable iff (!rst_n)
        cor_vld[0] |-> (norm_ok(cor_lane[0][0]) && norm_ok(cor_lane[0][1])
                        && norm_ok(cor_lane[0][2])))
        else $error("cordic input not normalized");
`endif

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// testbench for the two link leg inverse kinematics block: random targets, link settings, predicted angles
module tb_top;
    import tlik_pkg::*;

    typedef struct {
        logic signed [OUT_W-1:0] hip;
        logic signed [OUT_W-1:0] knee;
    } angle_pair_t;

    class ik_scoreboard;
        longint                  upper_len;
        longint                  lower_len;
        longint                  atan_tab[CORDIC_STEPS];
        angle_pair_t             expected_angles[$];
        int                      mismatches;

        function new();
            longint sum;
            longint term;
            int     sh;
            upper_len  = 13107;
            lower_len  = 13107;
            mismatches = 0;
            atan_tab[0] = QUARTER_PI_Q60;
            for (int i = 1; i < CORDIC_STEPS; i++)
            begin
                sum = 0;
                for (int k = 0; k < 64; k++)
                begin
                    sh = ANG_FRAC - i * (2 * k + 1);
                    if (sh >= 0)
                    begin
                        term = (longint'(1) << sh) / (2 * k + 1);
                        sum  = (k % 2 == 1) ? sum - term : sum + term;
                    end
                end
                atan_tab[i] = sum;
            end
        endfunction

        function void set_link(reg_idx_t idx, logic [LINK_W-1:0] val);
            if (idx == REG_UPPER)
                upper_len = val;
            else
                lower_len = val;
        endfunction

        function longint int_sqrt(longint unsigned n);
            longint unsigned res;
            longint unsigned bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > n)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (n >= res + bitv)
                begin
                    n   = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return longint'(res);
        endfunction

        function longint vec_angle(longint y, longint x);
            longint base;
            longint ang;
            longint dx;
            longint dy;
            base = 0;
            ang  = 0;
            if (y == 0)
                return (x < 0) ? PI_Q60 : 0;
            if (x == 0)
                return (y > 0) ? HALF_PI_Q60 : -HALF_PI_Q60;
            if (x < 0)
            begin
                base = (y > 0) ? PI_Q60 : -PI_Q60;
                x = -x;
                y = -y;
            end
            while ((x < 0 ? -x : x) < (longint'(1) << 56) && (y < 0 ? -y : y) < (longint'(1) << 56))
            begin
                x = x * 2;
                y = y * 2;
            end
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0)
                begin
                    x = x + dx;
                    y = y - dy;
                    ang = ang + atan_tab[i];
                end
                else
                begin
                    x = x - dx;
                    y = y + dy;
                    ang = ang - atan_tab[i];
                end
            end
            return base + ang;
        endfunction

        function longint cos_law_angle(longint num, longint den);
            longint mag;
            longint q;
            longint r;
            longint s;
            mag = (num < 0) ? -num : num;
            if (mag >= den)
                q = longint'(1) << ARG_BITS;
            else
            begin
                r = mag;
                q = 0;
                for (int b = 0; b < ARG_BITS; b++)
                begin
                    r = r << 1;
                    q = q << 1;
                    if (r >= den)
                    begin
                        r = r - den;
                        q = q | 1;
                    end
                end
            end
            if (num < 0)
                q = -q;
            s = int_sqrt((longint'(1) << (2 * ARG_BITS)) - q * q);
            return vec_angle(s, q);
        endfunction

        function logic signed [OUT_W-1:0] round_angle(longint v);
            longint r;
            r = (v + (longint'(1) << (ANG_FRAC - 1 - FRAC_BITS_DEF))) >>> (ANG_FRAC - FRAC_BITS_DEF);
            if (r > 524287)
                r = 524287;
            if (r < -524288)
                r = -524288;
            return r[OUT_W-1:0];
        endfunction

        function void note_target(logic signed [IN_W-1:0] tx, logic signed [IN_W-1:0] ty,
                                  logic signed [IN_W-1:0] tz);
            longint x, y, z, len, lmin, t0, t1, t2;
            angle_pair_t a;
            x = tx;
            y = ty;
            z = tz;
            lmin = ((longint'(1) << FRAC_BITS_DEF) + 500) / 1000;
            if (lmin < 1)
                lmin = 1;
            len = int_sqrt(x * x + y * y + z * z);
            if (len > upper_len + lower_len)
                len = upper_len + lower_len;
            if (len < lmin)
                len = lmin;
            t0 = vec_angle(x, z);
            if (t0 > 0)
                t0 = t0 - 2 * PI_Q60;
            t1 = cos_law_angle(upper_len * upper_len + len * len - lower_len * lower_len,
                               2 * upper_len * len);
            t2 = cos_law_angle(upper_len * upper_len + lower_len * lower_len - len * len,
                               2 * upper_len * lower_len);
            a.hip  = round_angle(t0 + PI_Q60 + t1);
            a.knee = round_angle(t2 - PI_Q60);
            expected_angles.push_back(a);
        endfunction

        function void check_angles(logic signed [OUT_W-1:0] hip, logic signed [OUT_W-1:0] knee);
            angle_pair_t a;
            if (expected_angles.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat hip=%0d knee=%0d", hip, knee);
                return;
            end
            a = expected_angles.pop_front();
            if (hip !== a.hip || knee !== a.knee)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("angle mismatch: hip exp %0d got %0d, knee exp %0d got %0d",
                             a.hip, hip, a.knee, knee);
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    wr_en;
    logic                    wr_index;
    logic [LINK_W-1:0]       wr_data;
    logic                    start;
    logic                    busy;
    logic signed [IN_W-1:0]  target_x;
    logic signed [IN_W-1:0]  target_y;
    logic signed [IN_W-1:0]  target_z;
    logic                    done;
    logic signed [OUT_W-1:0] hip_angle;
    logic signed [OUT_W-1:0] knee_angle;

    ik_scoreboard sb;
    int unsigned  cycle_count;

    two_link_leg_inverse_kinematics dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .start      (start),
        .busy       (busy),
        .target_x   (target_x),
        .target_y   (target_y),
        .target_z   (target_z),
        .done       (done),
        .hip_angle  (hip_angle),
        .knee_angle (knee_angle)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_target(target_x, target_y, target_z);
            if (done)
                sb.check_angles(hip_angle, knee_angle);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_target(logic signed [IN_W-1:0] x, logic signed [IN_W-1:0] y,
                               logic signed [IN_W-1:0] z, int gap);
        @(negedge clk);
        start    <= 1'b1;
        target_x <= x;
        target_y <= y;
        target_z <= z;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic write_link(reg_idx_t idx, logic [LINK_W-1:0] val);
        @(negedge clk);
        start    <= 1'b0;
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
        sb.set_link(idx, val);
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (sb.expected_angles.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_phase(int count);
        longint reach;
        longint m;
        for (int n = 0; n < count; n++)
        begin
            reach = sb.upper_len + sb.lower_len;
            m = (reach * 5) / 4 + 2;
            if (m > 8388607)
                m = 8388607;
            if ($urandom_range(0, 3) == 0)
                send_target($urandom, $urandom, $urandom, pick_gap());
            else
                send_target($urandom_range(0, 2 * m) - m, $urandom_range(0, 2 * m) - m,
                            $urandom_range(0, 2 * m) - m, pick_gap());
        end
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        wr_en       = 1'b0;
        wr_index    = 1'b0;
        wr_data     = '0;
        start       = 1'b0;
        target_x    = '0;
        target_y    = '0;
        target_z    = '0;
        cycle_count = 0;
        sb = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset lengths, directed corners
        send_target(0, 0, 0, 0);
        send_target(24'sh7FFFFF, 0, 0, 0);
        send_target(-24'sh800000, 0, 0, 0);
        send_target(0, 0, 24'sh7FFFFF, 1);
        send_target(0, 0, -24'sh800000, 0);
        send_target(0, 24'sh7FFFFF, 0, 0);
        send_target(0, -24'sh800000, 0, 2);
        send_target(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 0);
        send_target(-24'sh800000, -24'sh800000, -24'sh800000, 0);
        send_target(0, 0, -20000, 0);
        send_target(20, 10, -30, 0);
        send_target(1, 0, 0, 0);
        send_target(0, 0, 1, 0);
        send_target(-1, -1, -1, 3);
        send_target(10000, 0, -10000, 0);
        send_target(-10000, 5000, -10000, 0);
        send_target(0, 0, -26214, 0);
        send_target(0, 26214, 0, 0);
        send_target(26214, -1, 0, 0);
        random_phase(70);
        drain();

        write_link(REG_UPPER, 20'd1);
        write_link(REG_LOWER, 20'd1);
        send_target(0, 0, -1, 0);
        send_target(0, 0, -100, 0);
        random_phase(50);
        drain();

        write_link(REG_UPPER, 20'hFFFFF);
        write_link(REG_LOWER, 20'hFFFFF);
        send_target(0, 0, -24'sh200000, 0);
        random_phase(70);
        drain();

        // zero length links saturate the cosine argument
        write_link(REG_UPPER, 20'd0);
        write_link(REG_LOWER, 20'd20000);
        random_phase(30);
        drain();
        write_link(REG_UPPER, 20'd20000);
        write_link(REG_LOWER, 20'd0);
        random_phase(30);
        drain();

        write_link(REG_UPPER, 20'd30);
        write_link(REG_LOWER, 20'd20);
        random_phase(30);
        drain();

        for (int p = 0; p < 4; p++)
        begin
            write_link(REG_UPPER, $urandom_range(1, 20'hFFFFF) >> $urandom_range(0, 12));
            write_link(REG_LOWER, $urandom_range(1, 20'hFFFFF) >> $urandom_range(0, 12));
            random_phase(50);
            drain();
        end

        repeat (200) @(posedge clk);
        if (sb.expected_angles.size() != 0)
            sb.mismatches++;
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// ----- two_link_leg_inverse_kinematics.f -----
rtl/core/tlik_pkg.sv
rtl/core/tlik_sqrt_cell.sv
rtl/core/tlik_div_cell.sv
rtl/core/tlik_cordic_cell.sv
rtl/core/two_link_leg_inverse_kinematics.sv
test/tb_top.sv
